// ===== rtl/sw5_pkg.sv =====
// shared types, constants and helpers for the five-sample window filter
package sw5_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int TIME_WIDTH_DEF   = 32;

  localparam int WIN_LEN     = 5;
  localparam int NPAIR       = 10;
  localparam int MAX_RES     = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int FILL_W      = 3;
  localparam int RANK_W      = 3;

  localparam logic [FILL_W-1:0] FILL_FULL = 3'd5;
  localparam logic [FILL_W-1:0] FILL_EDGE = 3'd2;
  localparam logic [FILL_W-1:0] FILL_ONE_LEFT = 3'd3;
  localparam logic [RANK_W-1:0] MED_RANK  = 3'd2;

  // the ten unordered pairs of window positions
  localparam int PAIR_A [NPAIR] = '{0, 0, 0, 0, 1, 1, 1, 2, 2, 3};
  localparam int PAIR_B [NPAIR] = '{1, 2, 3, 4, 2, 3, 4, 3, 4, 4};

  typedef enum logic [1:0] {
    MODE_SIGMA  = 2'd0,
    MODE_MEDIAN = 2'd1,
    MODE_MEAN   = 2'd2
  } sw5_mode_t;

  // per-request control that rides along the arithmetic pipeline
  typedef struct packed {
    sw5_mode_t         mode;
    logic [FILL_W-1:0] fill;
    logic              last;
  } sw5_ctrl_t;

  function automatic int pair_idx(input int a, input int b);
    int r;
    r = 0;
    for (int p = 0; p < NPAIR; p++) begin
      if (PAIR_A[p] == a && PAIR_B[p] == b) begin
        r = p;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/sw5_calc.sv =====
// four-stage pipeline computing sigma test, median and mean and forming the results
module sw5_calc import sw5_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv_i,
  input  logic                           acc_i,
  input  sw5_ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] win_val_i  [WIN_LEN],
  input  logic        [TIME_WIDTH-1:0]   win_time_i [MAX_RES],
  output logic                           res_valid_o,
  output logic        [1:0]              res_cnt_o,
  output logic        [TIME_WIDTH-1:0]   res_time_o [MAX_RES],
  output logic signed [SAMPLE_WIDTH-1:0] res_val_o  [MAX_RES],
  output logic                           res_last_o [MAX_RES]
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int TW    = TIME_WIDTH;
  localparam int XW    = SW + 3;
  localparam int MW    = SW + 2;
  localparam int PSQW  = 2 * SW;
  localparam int HALFW = 2 * SW + 3;
  localparam int SQW   = 2 * SW + 4;
  localparam int PRW   = 2 * SW + 2;
  localparam int K     = SW + 2;
  localparam logic [SW-1:0] RECIP = SW'((64'd1 << K) / 64'd5);

  // stage 1: control only, the window itself sits in the top level
  logic      s1_vld_r;
  sw5_ctrl_t s1_ctrl_r;

  // stage 1 combinational
  logic signed [XW-1:0] xs [WIN_LEN];
  logic signed [XW-1:0] sum_s;
  logic signed [XW-1:0] c5;
  logic signed [XW-1:0] dev;
  logic        [MW-1:0] devmag;
  logic signed [SW:0]   dif  [NPAIR];
  logic        [SW-1:0] dmag [NPAIR];
  logic [NPAIR-1:0]     gt;

  // stage 2
  logic                 s2_vld_r;
  sw5_ctrl_t            s2_ctrl_r;
  logic        [SW-1:0] s2_dmag_r [NPAIR];
  logic        [MW-1:0] s2_devmag_r;
  logic signed [XW-1:0] s2_sum_r;
  logic [NPAIR-1:0]     s2_gt_r;
  logic signed [SW-1:0] s2_val_r  [WIN_LEN];
  logic        [TW-1:0] s2_time_r [MAX_RES];

  logic        [PSQW-1:0]   psq [NPAIR];
  logic        [SQW-1:0]    devsq;
  logic        [RANK_W-1:0] rank [WIN_LEN];
  logic signed [SW-1:0]     med;
  logic                     neg;
  logic        [MW-1:0]     mabs;
  logic        [PRW-1:0]    prod;

  // stage 3
  logic                 s3_vld_r;
  sw5_ctrl_t            s3_ctrl_r;
  logic      [PSQW-1:0] s3_psq_r [NPAIR];
  logic      [SQW-1:0]  s3_devsq_r;
  logic signed [SW-1:0] s3_med_r;
  logic      [MW-1:0]   s3_m_r;
  logic      [PRW-1:0]  s3_prod_r;
  logic                 s3_neg_r;
  logic signed [SW-1:0] s3_val_r  [MAX_RES];
  logic        [TW-1:0] s3_time_r [MAX_RES];

  logic [HALFW-1:0] sa;
  logic [HALFW-1:0] sb;
  logic [SW-1:0]    q0;
  logic [MW-1:0]    five_q;
  logic [3:0]       rem;

  // stage 4
  logic                 s4_vld_r;
  sw5_ctrl_t            s4_ctrl_r;
  logic     [HALFW-1:0] s4_sa_r;
  logic     [HALFW-1:0] s4_sb_r;
  logic     [SQW-1:0]   s4_devsq_r;
  logic signed [SW-1:0] s4_med_r;
  logic     [SW-1:0]    s4_q0_r;
  logic     [3:0]       s4_rem_r;
  logic                 s4_neg_r;
  logic signed [SW-1:0] s4_val_r  [MAX_RES];
  logic        [TW-1:0] s4_time_r [MAX_RES];

  logic [SQW-1:0]       tot;
  logic                 keep;
  logic [SW-1:0]        q;
  logic signed [SW-1:0] mean;

  function automatic logic rem_ge5(input logic [3:0] r);
    return r >= 4'd5;
  endfunction

  // ---------------- stage 1 -> 2
  always_comb begin
    sum_s = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      xs[i] = XW'(win_val_i[i]);
      sum_s = sum_s + xs[i];
    end
    c5     = (xs[2] <<< 2) + xs[2];
    dev    = c5 - sum_s;
    devmag = dev[XW-1] ? MW'(-dev) : MW'(dev);
    for (int p = 0; p < NPAIR; p++) begin
      dif[p]  = (SW+1)'(win_val_i[PAIR_A[p]]) - (SW+1)'(win_val_i[PAIR_B[p]]);
      dmag[p] = dif[p][SW] ? SW'(-dif[p]) : SW'(dif[p]);
      gt[p]   = !dif[p][SW] && (dif[p] != '0);
    end
  end

  // ---------------- stage 2 -> 3
  always_comb begin
    for (int p = 0; p < NPAIR; p++) begin
      psq[p] = PSQW'(s2_dmag_r[p]) * PSQW'(s2_dmag_r[p]);
    end
    devsq = SQW'(s2_devmag_r) * SQW'(s2_devmag_r);
    // rank of each sample in sorted order, ties broken by position
    med = '0;
    for (int i = 0; i < WIN_LEN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (j < i) begin
          rank[i] = rank[i] + RANK_W'(!s2_gt_r[pair_idx(j, i)]);
        end else if (j > i) begin
          rank[i] = rank[i] + RANK_W'(s2_gt_r[pair_idx(i, j)]);
        end
      end
      if (rank[i] == MED_RANK) begin
        med = s2_val_r[i];
      end
    end
    neg  = s2_sum_r[XW-1];
    mabs = neg ? MW'(-s2_sum_r) : MW'(s2_sum_r);
    prod = PRW'(mabs) * PRW'(RECIP);
  end

  // ---------------- stage 3 -> 4
  always_comb begin
    sa = '0;
    sb = '0;
    for (int p = 0; p < NPAIR / 2; p++) begin
      sa = sa + HALFW'(s3_psq_r[p]);
      sb = sb + HALFW'(s3_psq_r[p + NPAIR / 2]);
    end
    // reciprocal estimate is low by at most one
    q0     = SW'(s3_prod_r >> K);
    five_q = (MW'(q0) << 2) + MW'(q0);
    rem    = 4'(s3_m_r - five_q);
  end

  // ---------------- stage 4: decision and result list
  always_comb begin
    tot  = SQW'(s4_sa_r) + SQW'(s4_sb_r);
    keep = !(s4_devsq_r > tot);
    q    = s4_q0_r + SW'(rem_ge5(s4_rem_r));
    mean = s4_neg_r ? $signed(-q) : $signed(q);

    res_cnt_o = 2'd0;
    for (int r = 0; r < MAX_RES; r++) begin
      res_time_o[r] = s4_time_r[2];
      res_val_o[r]  = s4_val_r[2];
      res_last_o[r] = 1'b0;
    end

    case (s4_ctrl_r.mode)
      MODE_SIGMA: begin
        if (s4_ctrl_r.fill <= FILL_EDGE) begin
          res_cnt_o     = 2'd1;
          res_last_o[0] = s4_ctrl_r.last;
        end else if (s4_ctrl_r.fill < FILL_FULL) begin
          if (s4_ctrl_r.last) begin
            if (s4_ctrl_r.fill == FILL_ONE_LEFT) begin
              res_cnt_o     = 2'd1;
              res_last_o[0] = 1'b1;
            end else begin
              res_cnt_o     = 2'd2;
              res_time_o[0] = s4_time_r[1];
              res_val_o[0]  = s4_val_r[1];
              res_last_o[1] = 1'b1;
            end
          end
        end else if (keep) begin
          res_time_o[0] = s4_time_r[0];
          res_val_o[0]  = s4_val_r[0];
          if (s4_ctrl_r.last) begin
            res_cnt_o     = 2'd3;
            res_time_o[1] = s4_time_r[1];
            res_val_o[1]  = s4_val_r[1];
            res_last_o[2] = 1'b1;
          end else begin
            res_cnt_o = 2'd1;
          end
        end else if (s4_ctrl_r.last) begin
          res_cnt_o     = 2'd2;
          res_time_o[0] = s4_time_r[1];
          res_val_o[0]  = s4_val_r[1];
          res_last_o[1] = 1'b1;
        end
      end
      MODE_MEDIAN: begin
        if (s4_ctrl_r.fill == FILL_FULL) begin
          res_cnt_o     = 2'd1;
          res_time_o[0] = s4_time_r[0];
          res_val_o[0]  = s4_med_r;
          res_last_o[0] = s4_ctrl_r.last;
        end
      end
      MODE_MEAN: begin
        if (s4_ctrl_r.fill == FILL_FULL) begin
          res_cnt_o     = 2'd1;
          res_time_o[0] = s4_time_r[0];
          res_val_o[0]  = mean;
          res_last_o[0] = s4_ctrl_r.last;
        end
      end
      default: begin
        res_cnt_o = 2'd0;
      end
    endcase
  end

  assign res_valid_o = s4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv_i) begin
      s1_vld_r <= acc_i;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      s1_ctrl_r <= ctrl_i;

      s2_ctrl_r   <= s1_ctrl_r;
      s2_dmag_r   <= dmag;
      s2_devmag_r <= devmag;
      s2_sum_r    <= sum_s;
      s2_gt_r     <= gt;
      s2_val_r    <= win_val_i;
      s2_time_r   <= win_time_i;

      s3_ctrl_r  <= s2_ctrl_r;
      s3_psq_r   <= psq;
      s3_devsq_r <= devsq;
      s3_med_r   <= med;
      s3_m_r     <= mabs;
      s3_prod_r  <= prod;
      s3_neg_r   <= neg;
      for (int r = 0; r < MAX_RES; r++) begin
        s3_val_r[r] <= s2_val_r[r + 2];
      end
      s3_time_r <= s2_time_r;

      s4_ctrl_r  <= s3_ctrl_r;
      s4_sa_r    <= sa;
      s4_sb_r    <= sb;
      s4_devsq_r <= s3_devsq_r;
      s4_med_r   <= s3_med_r;
      s4_q0_r    <= q0;
      s4_rem_r   <= rem;
      s4_neg_r   <= s3_neg_r;
      s4_val_r   <= s3_val_r;
      s4_time_r  <= s3_time_r;
    end
  end

endmodule

// ===== rtl/sw5_outq.sv =====
// result queue taking up to three results per cycle and handing out one per cycle while out_ready_i is high
module sw5_outq import sw5_pkg::*; #(
  parameter int WIDTH = SAMPLE_WIDTH_DEF + TIME_WIDTH_DEF + 1,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n_i,
  input  logic [WIDTH-1:0] push_data_i [MAX_RES],
  output logic             room_o,
  output logic             out_valid_o,
  output logic [WIDTH-1:0] out_data_o,
  input  logic             out_ready_i
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid_o = (cnt_r != '0);
  assign out_data_o  = mem_r[rd_ptr_r];
  assign pop         = out_valid_o && out_ready_i;
  // room for a full set of results from one request
  assign room_o      = (cnt_r <= CW'(DEPTH - MAX_RES));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_n_i);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    cnt_nxt    = cnt_r + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (2'(i) < push_n_i) begin
        mem_r[wr_ptr_r + PW'(i)] <= push_data_i[i];
      end
    end
  end

endmodule

// ===== rtl/sliding_window5_filter_top.sv =====
// Five-sample sliding window filter over timestamped samples. One request is taken
// per clock cycle while in_tready is high; each request passes the four-stage arithmetic
// pipeline and its zero to three results enter an eight-entry result queue, which offers
// its oldest result on out_tvalid. The queue hands out one result per cycle while
// out_tready is high. in_tready drops while the queue has fewer than three free
// entries, so the sustained input rate is one request per cycle as long as requests
// average at most one result and the output side keeps taking them.
// filter_mode selects sigma outlier removal (0), median (1) or mean (2); write it only
// while the block is idle.
module sliding_window5_filter_top import sw5_pkg::*; #(
  parameter  int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter  int TIME_WIDTH   = TIME_WIDTH_DEF,
  localparam int DATA_W       = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // sample_time, sample_value, zero fill
  input  logic              in_tlast,   // end_of_series
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // out_time, out_value, zero fill
  output logic              out_tlast,  // out_last
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int QW = TW + SW + 1;

  logic                 accept;
  logic                 adv;
  logic        [TW-1:0] in_time;
  logic signed [SW-1:0] in_value;
  logic [FILL_W-1:0]    fill_r, fill_nxt, k_fill;
  sw5_mode_t            mode_r;
  sw5_ctrl_t            ctrl;

  logic signed [SW-1:0] w_val_r  [WIN_LEN];
  logic        [TW-1:0] w_time_r [WIN_LEN];
  logic        [TW-1:0] ctr_time [MAX_RES];

  logic                 res_valid;
  logic [1:0]           res_cnt;
  logic        [TW-1:0] res_time [MAX_RES];
  logic signed [SW-1:0] res_val  [MAX_RES];
  logic                 res_last [MAX_RES];
  logic [1:0]           push_n;
  logic [QW-1:0]        push_data [MAX_RES];
  logic [QW-1:0]        q_data;

  assign in_time  = in_tdata[TW-1:0];
  assign in_value = $signed(in_tdata[TW+SW-1:TW]);
  assign in_tready = adv;
  assign accept   = in_tvalid && in_tready;

  always_comb begin
    k_fill   = (fill_r < FILL_FULL) ? fill_r + FILL_W'(1) : FILL_FULL;
    fill_nxt = in_tlast ? '0 : k_fill;
    ctrl     = '{mode: mode_r, fill: k_fill, last: in_tlast};
    for (int r = 0; r < MAX_RES; r++) begin
      ctr_time[r] = w_time_r[r + 2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      mode_r <= MODE_SIGMA;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= sw5_mode_t'(cfg_wr_data);
      end
      if (accept) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // window shifts toward index 0, newest sample at index 4
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        w_val_r[i]  <= w_val_r[i + 1];
        w_time_r[i] <= w_time_r[i + 1];
      end
      w_val_r[WIN_LEN-1]  <= in_value;
      w_time_r[WIN_LEN-1] <= in_time;
    end
  end

  sw5_calc #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_calc (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv_i       (adv),
    .acc_i       (accept),
    .ctrl_i      (ctrl),
    .win_val_i   (w_val_r),
    .win_time_i  (ctr_time),
    .res_valid_o (res_valid),
    .res_cnt_o   (res_cnt),
    .res_time_o  (res_time),
    .res_val_o   (res_val),
    .res_last_o  (res_last)
  );

  always_comb begin
    push_n = (adv && res_valid) ? res_cnt : 2'd0;
    for (int r = 0; r < MAX_RES; r++) begin
      push_data[r] = {res_last[r], res_val[r], res_time[r]};
    end
  end

  sw5_outq #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .room_o      (adv),
    .out_valid_o (out_tvalid),
    .out_data_o  (q_data),
    .out_ready_i (out_tready)
  );

  assign out_tdata = DATA_W'(q_data[TW+SW-1:0]);
  assign out_tlast = q_data[QW-1];

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count above window length");

  a_series_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> fill_r == '0)
    else $error("fill count not cleared after end of series");

  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(fill_r))
    else $error("fill count moved without a request");

endmodule
